// ===== rtl/bgk_collision_d1q3_macros.svh =====
// Assertion macros for the D1Q3 collision block.
// Used by the top level only; no other dependencies.
`ifndef BGK_COLLISION_D1Q3_MACROS_SVH
`define BGK_COLLISION_D1Q3_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BGK_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bgk_collision_d1q3 check failed");

// Next-cycle implication, disabled during reset
`define BGK_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bgk_collision_d1q3 check failed");

`endif

// ===== rtl/bgk_d1q3_pkg.sv =====
// Shared constants for the D1Q3 BGK collision block.
// No dependencies; compiled first.
package bgk_d1q3_pkg;

    // Configuration register widths and reset values
    localparam int C2_W       = 17;
    localparam int RATE_W     = 31;
    localparam int COEF_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int FAULT_W    = 2;

    localparam logic [C2_W-1:0]   C2_RESET   = 17'd32768;
    localparam logic [RATE_W-1:0] RATE_RESET = 31'd65536;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_SPEED_SQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX_RATE     = 2'd1;

    // Operations
    localparam logic OP_RELAX   = 1'b0;
    localparam logic OP_PROJECT = 1'b1;

    // Fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE         = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_ZERO_DENSITY = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_ZERO_DENOM   = 2'd2;

endpackage

// ===== rtl/bgk_d1q3_if.sv =====
// Channel interfaces for the D1Q3 collision block: node input, result, config write.
// Depends on bgk_d1q3_pkg.
interface bgk_d1q3_in_if #(parameter int DATA_WIDTH = 32);
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic signed [DATA_WIDTH-1:0] pop0_re;
    logic signed [DATA_WIDTH-1:0] pop0_im;
    logic signed [DATA_WIDTH-1:0] pop1_re;
    logic signed [DATA_WIDTH-1:0] pop1_im;
    logic signed [DATA_WIDTH-1:0] pop2_re;
    logic signed [DATA_WIDTH-1:0] pop2_im;
    logic signed [DATA_WIDTH-1:0] step_re;
    logic signed [DATA_WIDTH-1:0] step_im;

    modport source (output valid, operation, pop0_re, pop0_im, pop1_re, pop1_im,
                    pop2_re, pop2_im, step_re, step_im, input ready);
    modport sink   (input valid, operation, pop0_re, pop0_im, pop1_re, pop1_im,
                    pop2_re, pop2_im, step_re, step_im, output ready);
endinterface

interface bgk_d1q3_out_if #(parameter int DATA_WIDTH = 32);
    logic                                valid;
    logic                                ready;
    logic signed [DATA_WIDTH-1:0]        new0_re;
    logic signed [DATA_WIDTH-1:0]        new0_im;
    logic signed [DATA_WIDTH-1:0]        new1_re;
    logic signed [DATA_WIDTH-1:0]        new1_im;
    logic signed [DATA_WIDTH-1:0]        new2_re;
    logic signed [DATA_WIDTH-1:0]        new2_im;
    logic [bgk_d1q3_pkg::FAULT_W-1:0]    fault;

    modport source (output valid, new0_re, new0_im, new1_re, new1_im, new2_re, new2_im,
                    fault, input ready);
    modport sink   (input valid, new0_re, new0_im, new1_re, new1_im, new2_re, new2_im,
                    fault, output ready);
endinterface

interface bgk_d1q3_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [bgk_d1q3_pkg::CFG_IDX_W-1:0]   index;
    logic [bgk_d1q3_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bgk_d1q3_div.sv =====
// Pipelined signed fixed-point divider, one quotient bit per stage.
// Rounds to nearest (halves away from zero) and saturates; standalone.
module bgk_d1q3_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [2*W:0] i_num,
    input  logic [2*W-1:0]      i_den,
    output logic signed [W-1:0] o_quo
);
    localparam int NW = 2*W + 1;
    localparam int DW = 2*W;
    localparam int MW = NW + F + 1;
    localparam int CW = (MW > 3*W) ? MW : 3*W;
    localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAXQ = {1'b0, {(W-1){1'b1}}};

    // Front stages: magnitude, rounding bias, overflow check
    logic          r0_neg, r1_neg;
    logic [NW-1:0] r0_mag, n0_mag;
    logic [DW-1:0] r0_den, r1_den;
    logic [MW-1:0] r1_m, n1_m, n2_sh;

    // Bit stages
    logic          r_neg [0:W];
    logic          r_ovf [0:W];
    logic [DW-1:0] r_den [0:W];
    logic [DW-1:0] r_rem [0:W];
    logic [W-1:0]  r_low [0:W];
    logic [W-1:0]  r_q   [0:W];
    logic [W-1:0]  n_quo;

    assign n0_mag = i_num[NW-1] ? (NW'(0) - $unsigned(i_num)) : $unsigned(i_num);
    assign n1_m   = (MW'(r0_mag) << F) + MW'(r0_den >> 1);
    assign n2_sh  = r1_m >> W;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_neg   <= i_num[NW-1];
            r0_mag   <= n0_mag;
            r0_den   <= i_den;
            r1_neg   <= r0_neg;
            r1_den   <= r0_den;
            r1_m     <= n1_m;
            r_neg[0] <= r1_neg;
            r_den[0] <= r1_den;
            r_ovf[0] <= CW'(r1_m) >= (CW'(r1_den) << W);
            r_rem[0] <= n2_sh[DW-1:0];
            r_low[0] <= r1_m[W-1:0];
            r_q[0]   <= '0;
        end
    end

    // One restoring step per stage
    for (genvar k = 0; k < W; k++) begin : g_step
        logic [DW:0]   rem_in;
        logic          ge;
        logic [DW-1:0] n_rem;
        always_comb begin
            rem_in = {r_rem[k], r_low[k][W-1]};
            ge     = rem_in >= {1'b0, r_den[k]};
            n_rem  = ge ? DW'(rem_in - {1'b0, r_den[k]}) : rem_in[DW-1:0];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
                r_den[k+1] <= r_den[k];
                r_rem[k+1] <= n_rem;
                r_low[k+1] <= r_low[k] << 1;
                r_q[k+1]   <= {r_q[k][W-2:0], ge};
            end
        end
    end

    // Sign and saturation
    always_comb begin
        if (r_ovf[W]) begin
            n_quo = r_neg[W] ? HALF : MAXQ;
        end else if (!r_neg[W]) begin
            n_quo = (r_q[W] > MAXQ) ? MAXQ : r_q[W];
        end else begin
            n_quo = (r_q[W] > HALF) ? HALF : (W'(0) - r_q[W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quo <= $signed(n_quo);
        end
    end
endmodule

// ===== rtl/bgk_collision_d1q3.sv =====
// Top level of the D1Q3 lattice BGK collision pipeline.
// Depends on bgk_d1q3_pkg, bgk_d1q3_if, bgk_d1q3_div and bgk_collision_d1q3_macros.svh.
//
// Usage:
//   i_in  : one lattice node per transfer (operation, three complex populations,
//           complex time step). o_out: the three updated populations and a fault code.
//   i_cfg : register writes (index 0 sound speed squared, 1 relaxation rate);
//           always ready, write only while no node is in flight.
// Pipeline: DATA_WIDTH + 15 register stages, of which DATA_WIDTH + 4 are the
//   bit-per-stage dividers.
// Throughput: one node per cycle while the output is not stalled; every stage is a register with a valid bit.
// Reset: synchronous, active low; clears all valid bits and loads the register
//   defaults (sound speed squared 0.5, rate 1.0). Data registers are not reset.
// Stall: the whole pipeline holds while the result register is full and not
//   taken; i_in.ready drops in the same cycle, so nothing is lost or repeated.
// Faults: zero density, or zero 1+z in relax mode, pass the populations through.
module bgk_collision_d1q3 #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bgk_d1q3_cfg_if.sink      i_cfg,
    bgk_d1q3_in_if.sink       i_in,
    bgk_d1q3_out_if.source    o_out
);
    import bgk_d1q3_pkg::*;

    localparam int W       = DATA_WIDTH;
    localparam int F       = FRAC_BITS;
    localparam int NW      = 2*W + 1;
    localparam int DW      = 2*W;
    localparam int EW      = (2*W + 4 > W + COEF_W + 2) ? 2*W + 4 : W + COEF_W + 2;
    localparam int DIV_LAT = W + 4;
    localparam int NSTG    = 5 + DIV_LAT + 6;
    localparam logic signed [EW-1:0] MAXE  = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] MINE  = {{(EW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [EW-1:0] ONE_E = EW'(1) << F;

    typedef struct packed {
        logic signed [W-1:0] re;
        logic signed [W-1:0] im;
    } t_cpx;

    typedef struct packed {
        logic op;
        t_cpx w0;
        t_cpx w1;
        t_cpx w2;
        t_cpx r;
        t_cpx q;
        t_cpx c2r;
        logic zd;
        logic opzz;
    } t_side;

    typedef struct packed {
        t_side sd;
        t_cpx  a;
        t_cpx  b;
        t_cpx  eq0;
        t_cpx  eq1;
        t_cpx  eq2;
    } t_post;

    // ---------------- arithmetic helpers ----------------
    function automatic logic signed [EW-1:0] f_ext(input logic signed [W-1:0] a);
        return EW'(a);
    endfunction

    function automatic logic signed [W-1:0] f_sat(input logic signed [EW-1:0] v);
        logic signed [W-1:0] res;
        if (v > MAXE) begin
            res = MAXE[W-1:0];
        end else if (v < MINE) begin
            res = MINE[W-1:0];
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    // round half up by F (sel=0) or F+1 (sel=1) bits, then saturate
    function automatic logic signed [W-1:0] f_rnd(input logic signed [EW-1:0] v,
                                                  input logic sel);
        logic signed [EW-1:0] t;
        t = v + (EW'(1) << (F - 1 + sel));
        t = t >>> (F + sel);
        return f_sat(t);
    endfunction

    function automatic logic signed [EW-1:0] f_mul(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        logic signed [2*W-1:0] p;
        p = a * b;
        return EW'(p);
    endfunction

    function automatic logic signed [EW-1:0] f_mulc(input logic signed [W-1:0] a,
                                                   input logic [COEF_W-1:0] b);
        logic signed [W+COEF_W:0] p;
        p = a * $signed({1'b0, b});
        return EW'(p);
    endfunction

    // ---------------- configuration ----------------
    logic [C2_W-1:0]         r_c2;
    logic [RATE_W-1:0]       r_rate;
    logic [COEF_W-1:0]       c2_lane, rate_lane;
    logic signed [EW-1:0]    c2_e;

    assign i_cfg.ready = 1'b1;
    assign c2_lane     = COEF_W'(r_c2);
    assign rate_lane   = COEF_W'(r_rate);
    assign c2_e        = $signed(EW'(r_c2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2   <= C2_RESET;
            r_rate <= RATE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SOUND_SPEED_SQ: r_c2   <= i_cfg.data[C2_W-1:0];
                CFG_RELAX_RATE:     r_rate <= i_cfg.data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic            en;
    logic [NSTG-1:0] r_v;
    logic            r_out_v;

    assign r_out_v    = r_v[NSTG-1];
    assign en         = !r_out_v || o_out.ready;
    assign i_in.ready = en;
    assign o_out.valid = r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTG-2:0], i_in.valid};
        end
    end

    // ---------------- stage registers ----------------
    t_side                r1_sd, r2_sd, r3_sd, r4_sd, r5_sd;
    t_side                n1_sd, n2_sd, n3_sd;
    logic signed [EW-1:0] r1_zp_re, r1_zp_im;
    t_cpx                 r2_z;
    logic signed [EW-1:0] r2_cp_re, r2_cp_im;
    logic signed [EW-1:0] r2_up [6];
    t_cpx                 r3_opz, r3_omz, r3_z2, n3_opz;
    logic signed [EW-1:0] r3_un_re, r3_un_im, r3_ud;
    logic signed [EW-1:0] r4_ap [4];
    logic signed [EW-1:0] r4_bp [4];
    logic signed [EW-1:0] r4_dp [2];
    logic signed [EW-1:0] r4_un_re, r4_un_im, r4_ud;
    logic signed [EW-1:0] r5_un_re, r5_un_im, r5_ud;
    logic signed [EW-1:0] r5_an_re, r5_an_im, r5_bn_re, r5_bn_im, r5_zd_den;
    t_side                r_dly [DIV_LAT];
    logic signed [W-1:0]  u_re, u_im, a_re, a_im, b_re, b_im;

    // stage 1: density, momentum, z products
    always_comb begin
        n1_sd      = '0;
        n1_sd.op   = i_in.operation;
        n1_sd.w0   = '{re: i_in.pop0_re, im: i_in.pop0_im};
        n1_sd.w1   = '{re: i_in.pop1_re, im: i_in.pop1_im};
        n1_sd.w2   = '{re: i_in.pop2_re, im: i_in.pop2_im};
        n1_sd.r.re = f_sat(f_ext(i_in.pop0_re) + f_ext(i_in.pop1_re) + f_ext(i_in.pop2_re));
        n1_sd.r.im = f_sat(f_ext(i_in.pop0_im) + f_ext(i_in.pop1_im) + f_ext(i_in.pop2_im));
        n1_sd.q.re = f_sat(f_ext(i_in.pop2_re) - f_ext(i_in.pop0_re));
        n1_sd.q.im = f_sat(f_ext(i_in.pop2_im) - f_ext(i_in.pop0_im));
    end

    // stage 2: zero density flag, round z
    always_comb begin
        n2_sd    = r1_sd;
        n2_sd.zd = (r1_sd.r == '0);
    end

    // stage 3: 1+z, 1-z, 2z, c2*r/2
    always_comb begin
        n3_sd        = r2_sd;
        n3_sd.c2r.re = f_rnd(r2_cp_re, 1'b1);
        n3_sd.c2r.im = f_rnd(r2_cp_im, 1'b1);
        n3_opz.re    = f_sat(ONE_E + f_ext(r2_z.re));
        n3_opz.im    = r2_z.im;
        n3_sd.opzz   = (n3_opz == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sd    <= n1_sd;
            r1_zp_re <= f_mulc(i_in.step_re, rate_lane);
            r1_zp_im <= f_mulc(i_in.step_im, rate_lane);

            r2_sd    <= n2_sd;
            r2_z.re  <= f_rnd(r1_zp_re, 1'b1);
            r2_z.im  <= f_rnd(r1_zp_im, 1'b1);
            r2_cp_re <= f_mulc(r1_sd.r.re, c2_lane);
            r2_cp_im <= f_mulc(r1_sd.r.im, c2_lane);
            r2_up[0] <= f_mul(r1_sd.q.re, r1_sd.r.re);
            r2_up[1] <= f_mul(r1_sd.q.im, r1_sd.r.im);
            r2_up[2] <= f_mul(r1_sd.q.im, r1_sd.r.re);
            r2_up[3] <= f_mul(r1_sd.q.re, r1_sd.r.im);
            r2_up[4] <= f_mul(r1_sd.r.re, r1_sd.r.re);
            r2_up[5] <= f_mul(r1_sd.r.im, r1_sd.r.im);

            r3_sd     <= n3_sd;
            r3_opz    <= n3_opz;
            r3_omz.re <= f_sat(ONE_E - f_ext(r2_z.re));
            r3_omz.im <= f_sat(-f_ext(r2_z.im));
            r3_z2.re  <= f_sat(f_ext(r2_z.re) + f_ext(r2_z.re));
            r3_z2.im  <= f_sat(f_ext(r2_z.im) + f_ext(r2_z.im));
            r3_un_re  <= r2_up[0] + r2_up[1];
            r3_un_im  <= r2_up[2] - r2_up[3];
            r3_ud     <= r2_up[4] + r2_up[5];

            // stage 4: products for (1-z)/(1+z) and 2z/(1+z)
            r4_sd    <= r3_sd;
            r4_ap[0] <= f_mul(r3_omz.re, r3_opz.re);
            r4_ap[1] <= f_mul(r3_omz.im, r3_opz.im);
            r4_ap[2] <= f_mul(r3_omz.im, r3_opz.re);
            r4_ap[3] <= f_mul(r3_omz.re, r3_opz.im);
            r4_bp[0] <= f_mul(r3_z2.re, r3_opz.re);
            r4_bp[1] <= f_mul(r3_z2.im, r3_opz.im);
            r4_bp[2] <= f_mul(r3_z2.im, r3_opz.re);
            r4_bp[3] <= f_mul(r3_z2.re, r3_opz.im);
            r4_dp[0] <= f_mul(r3_opz.re, r3_opz.re);
            r4_dp[1] <= f_mul(r3_opz.im, r3_opz.im);
            r4_un_re <= r3_un_re;
            r4_un_im <= r3_un_im;
            r4_ud    <= r3_ud;

            // stage 5: divider operands
            r5_sd     <= r4_sd;
            r5_an_re  <= r4_ap[0] + r4_ap[1];
            r5_an_im  <= r4_ap[2] - r4_ap[3];
            r5_bn_re  <= r4_bp[0] + r4_bp[1];
            r5_bn_im  <= r4_bp[2] - r4_bp[3];
            r5_zd_den <= r4_dp[0] + r4_dp[1];
            r5_un_re  <= r4_un_re;
            r5_un_im  <= r4_un_im;
            r5_ud     <= r4_ud;
        end
    end

    // ---------------- dividers: u = q/r, a, b ----------------
    bgk_d1q3_div #(.W(W), .F(F)) u_div_ure (
        .i_clk(i_clk), .i_en(en), .i_num(r5_un_re[NW-1:0]), .i_den(r5_ud[DW-1:0]),
        .o_quo(u_re));
    bgk_d1q3_div #(.W(W), .F(F)) u_div_uim (
        .i_clk(i_clk), .i_en(en), .i_num(r5_un_im[NW-1:0]), .i_den(r5_ud[DW-1:0]),
        .o_quo(u_im));
    bgk_d1q3_div #(.W(W), .F(F)) u_div_are (
        .i_clk(i_clk), .i_en(en), .i_num(r5_an_re[NW-1:0]), .i_den(r5_zd_den[DW-1:0]),
        .o_quo(a_re));
    bgk_d1q3_div #(.W(W), .F(F)) u_div_aim (
        .i_clk(i_clk), .i_en(en), .i_num(r5_an_im[NW-1:0]), .i_den(r5_zd_den[DW-1:0]),
        .o_quo(a_im));
    bgk_d1q3_div #(.W(W), .F(F)) u_div_bre (
        .i_clk(i_clk), .i_en(en), .i_num(r5_bn_re[NW-1:0]), .i_den(r5_zd_den[DW-1:0]),
        .o_quo(b_re));
    bgk_d1q3_div #(.W(W), .F(F)) u_div_bim (
        .i_clk(i_clk), .i_en(en), .i_num(r5_bn_im[NW-1:0]), .i_den(r5_zd_den[DW-1:0]),
        .o_quo(b_im));

    // side data runs alongside the dividers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= r5_sd;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    // ---------------- equilibrium and update ----------------
    t_post                r6_ps, r7_ps, r8_ps, r9_ps, r10_ps, n6_ps, n8_ps, n9_ps;
    t_cpx                 r6_um1, r6_up1, r7_t, n7_t;
    logic signed [EW-1:0] r6_prr, r6_pii, r6_pri;
    logic signed [EW-1:0] r7_hm [4];
    logic signed [EW-1:0] r7_hp [4];
    logic signed [EW-1:0] r8_rt [4];
    logic signed [EW-1:0] r10_pa [3][4];
    logic signed [EW-1:0] r10_pb [3][4];
    logic signed [W-1:0]  n7_uu_re, n7_uu_im;
    t_cpx                 n8_h0, n8_h2;
    t_cpx                 n10_w [3];
    t_cpx                 n10_e [3];
    t_cpx                 n_res [3];
    logic [FAULT_W-1:0]   n_fault;
    t_cpx                 r_out_res [3];
    logic [FAULT_W-1:0]   r_out_fault;
    logic                 r_out_op;

    always_comb begin
        n6_ps      = '0;
        n6_ps.sd   = r_dly[DIV_LAT-1];
        n6_ps.a.re = a_re;
        n6_ps.a.im = a_im;
        n6_ps.b.re = b_re;
        n6_ps.b.im = b_im;
    end

    // u*u rounded, then t = 1 - u*u - c2
    always_comb begin
        n7_uu_re = f_rnd(r6_prr - r6_pii, 1'b0);
        n7_uu_im = f_rnd(r6_pri + r6_pri, 1'b0);
        n7_t.re  = f_sat(ONE_E - f_ext(n7_uu_re) - c2_e);
        n7_t.im  = f_sat(-f_ext(n7_uu_im));
    end

    // q(u-1)/2 and q(u+1)/2
    always_comb begin
        n8_h0.re = f_rnd(r7_hm[0] - r7_hm[1], 1'b1);
        n8_h0.im = f_rnd(r7_hm[2] + r7_hm[3], 1'b1);
        n8_h2.re = f_rnd(r7_hp[0] - r7_hp[1], 1'b1);
        n8_h2.im = f_rnd(r7_hp[2] + r7_hp[3], 1'b1);
    end

    // eq0 and eq2 into the side data
    always_comb begin
        n8_ps        = r7_ps;
        n8_ps.eq0.re = f_sat(f_ext(n8_h0.re) + f_ext(r7_ps.sd.c2r.re));
        n8_ps.eq0.im = f_sat(f_ext(n8_h0.im) + f_ext(r7_ps.sd.c2r.im));
        n8_ps.eq2.re = f_sat(f_ext(n8_h2.re) + f_ext(r7_ps.sd.c2r.re));
        n8_ps.eq2.im = f_sat(f_ext(n8_h2.im) + f_ext(r7_ps.sd.c2r.im));
    end

    // eq1 = r*t into the side data
    always_comb begin
        n9_ps        = r8_ps;
        n9_ps.eq1.re = f_rnd(r8_rt[0] - r8_rt[1], 1'b0);
        n9_ps.eq1.im = f_rnd(r8_rt[2] + r8_rt[3], 1'b0);
    end

    always_comb begin
        n10_w[0] = r9_ps.sd.w0;
        n10_w[1] = r9_ps.sd.w1;
        n10_w[2] = r9_ps.sd.w2;
        n10_e[0] = r9_ps.eq0;
        n10_e[1] = r9_ps.eq1;
        n10_e[2] = r9_ps.eq2;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage E1: u-1, u+1, u*u products
            r6_ps     <= n6_ps;
            r6_um1.re <= f_sat(f_ext(u_re) - ONE_E);
            r6_um1.im <= u_im;
            r6_up1.re <= f_sat(f_ext(u_re) + ONE_E);
            r6_up1.im <= u_im;
            r6_prr    <= f_mul(u_re, u_re);
            r6_pii    <= f_mul(u_im, u_im);
            r6_pri    <= f_mul(u_re, u_im);

            // stage E2: t and momentum products
            r7_ps    <= r6_ps;
            r7_t     <= n7_t;
            r7_hm[0] <= f_mul(r6_ps.sd.q.re, r6_um1.re);
            r7_hm[1] <= f_mul(r6_ps.sd.q.im, r6_um1.im);
            r7_hm[2] <= f_mul(r6_ps.sd.q.re, r6_um1.im);
            r7_hm[3] <= f_mul(r6_ps.sd.q.im, r6_um1.re);
            r7_hp[0] <= f_mul(r6_ps.sd.q.re, r6_up1.re);
            r7_hp[1] <= f_mul(r6_ps.sd.q.im, r6_up1.im);
            r7_hp[2] <= f_mul(r6_ps.sd.q.re, r6_up1.im);
            r7_hp[3] <= f_mul(r6_ps.sd.q.im, r6_up1.re);

            // stage E3: eq0, eq2, products for eq1
            r8_ps    <= n8_ps;
            r8_rt[0] <= f_mul(r7_ps.sd.r.re, r7_t.re);
            r8_rt[1] <= f_mul(r7_ps.sd.r.im, r7_t.im);
            r8_rt[2] <= f_mul(r7_ps.sd.r.re, r7_t.im);
            r8_rt[3] <= f_mul(r7_ps.sd.r.im, r7_t.re);

            // stage E4: eq1
            r9_ps <= n9_ps;

            // stage F1: a*pop_k and b*eq_k products
            r10_ps <= r9_ps;
            for (int k = 0; k < 3; k++) begin
                r10_pa[k][0] <= f_mul(r9_ps.a.re, n10_w[k].re);
                r10_pa[k][1] <= f_mul(r9_ps.a.im, n10_w[k].im);
                r10_pa[k][2] <= f_mul(r9_ps.a.re, n10_w[k].im);
                r10_pa[k][3] <= f_mul(r9_ps.a.im, n10_w[k].re);
                r10_pb[k][0] <= f_mul(r9_ps.b.re, n10_e[k].re);
                r10_pb[k][1] <= f_mul(r9_ps.b.im, n10_e[k].im);
                r10_pb[k][2] <= f_mul(r9_ps.b.re, n10_e[k].im);
                r10_pb[k][3] <= f_mul(r9_ps.b.im, n10_e[k].re);
            end
        end
    end

    // stage F2: final sums and mode / fault selection
    always_comb begin
        t_cpx w [3];
        t_cpx e [3];
        w[0] = r10_ps.sd.w0;
        w[1] = r10_ps.sd.w1;
        w[2] = r10_ps.sd.w2;
        e[0] = r10_ps.eq0;
        e[1] = r10_ps.eq1;
        e[2] = r10_ps.eq2;
        n_fault = FAULT_NONE;
        for (int k = 0; k < 3; k++) begin
            n_res[k].re = f_rnd(r10_pa[k][0] - r10_pa[k][1] + r10_pb[k][0] - r10_pb[k][1],
                                1'b0);
            n_res[k].im = f_rnd(r10_pa[k][2] + r10_pa[k][3] + r10_pb[k][2] + r10_pb[k][3],
                                1'b0);
        end
        if (r10_ps.sd.zd) begin
            n_fault = FAULT_ZERO_DENSITY;
            n_res   = w;
        end else if (r10_ps.sd.op == OP_PROJECT) begin
            n_res   = e;
        end else if (r10_ps.sd.opzz) begin
            n_fault = FAULT_ZERO_DENOM;
            n_res   = w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_res   <= n_res;
            r_out_fault <= n_fault;
            r_out_op    <= r10_ps.sd.op;
        end
    end

    assign o_out.new0_re = r_out_res[0].re;
    assign o_out.new0_im = r_out_res[0].im;
    assign o_out.new1_re = r_out_res[1].re;
    assign o_out.new1_im = r_out_res[1].im;
    assign o_out.new2_re = r_out_res[2].re;
    assign o_out.new2_im = r_out_res[2].im;
    assign o_out.fault   = r_out_fault;

    // ---------------- assertions ----------------
    `include "bgk_collision_d1q3_macros.svh"

    // input side stalls exactly when the result register is held
    `BGK_ASSERT_NOW(a_ready_tracks_out, i_clk, i_rst_n, 1'b1, i_in.ready == (!r_out_v || o_out.ready))
    // projection never reports a relaxation denominator fault
    `BGK_ASSERT_NOW(a_project_fault, i_clk, i_rst_n, r_out_v && (r_out_op == OP_PROJECT), o_out.fault != FAULT_ZERO_DENOM)
    // a held result keeps its fault code through the stall
    `BGK_ASSERT_NEXT(a_stall_fault, i_clk, i_rst_n, r_out_v && !o_out.ready, $stable(r_out_fault))

endmodule
